// ----- src/esd_pkg.sv -----
// shared types, character codes and helpers for the escape sequence decoder
package esd_pkg;

    localparam int ESD_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_C         = 8'h63;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_V         = 8'h76;
    localparam logic [7:0] CH_F         = 8'h66;

    localparam logic [7:0] CTL_BEL = 8'h07;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_HT  = 8'h09;
    localparam logic [7:0] CTL_VT  = 8'h0B;
    localparam logic [7:0] CTL_FF  = 8'h0C;

    // up to three results caused by one item, last is the index of the final one
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       has0;
        logic       done;
        logic [1:0] last;
    } t_bundle;

    // {valid, value} of a hex digit in either case
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ----- src/escape_sequence_decoder.sv -----
// top level of the escape sequence decoder: front end, bundle queue and back end
// One input item (a byte, or an end-of-string marker) is accepted in every cycle
// in which full is low; the front end decodes it in that same cycle and writes
// whatever it causes (zero to three results) as one bundle into a queue of
// QUEUE_DEPTH entries. The back end reads one bundle at a time and presents its
// results one per cycle while pop is held, through an output register; the single
// output port is what limits the sustained rate to one result per cycle. Between
// an accepted item and its first result on the result ports lie the queue entry
// and the output register, and a busy back end can hold the item in the queue.
// Items that cause no result (an opening backslash, hex digits still pending,
// any byte while output is suppressed) take no queue space and no output cycle.
// full rises only when the queue holds QUEUE_DEPTH bundles that the consumer has
// not yet drained.
module escape_sequence_decoder
    import esd_pkg::*;
#(
    parameter int QUEUE_DEPTH = ESD_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input side
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_item,
    // result side
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_string_done,
    output logic       o_last_of_run
);

    // bundles travelling from front to back
    t_bundle q_wr_data, q_rd_data;
    logic    q_push, q_full, q_pop, q_empty;

    // decode state and classification of each item
    esd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in_byte  (i_in_byte),
        .i_end_item (i_end_item),
        .o_full     (full),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wr_data)
    );

    // short queue so each side can stall on its own
    esd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    // unpacks bundles into single results
    esd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_data      (q_rd_data),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out_byte    (o_out_byte),
        .o_has_byte    (o_has_byte),
        .o_string_done (o_string_done),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ----- src/esd_front.sv -----
// front end: decode state and classification of each item into a result bundle
module esd_front
    import esd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_item,
    output logic       o_full,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_bundle    o_q_data
);

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_HEX0   = 3'd2;
    localparam logic [2:0] MODE_HEX1   = 3'd3;
    localparam logic [2:0] MODE_QUIET  = 3'd4;

    logic [2:0] r_mode, n_mode;
    logic [3:0] r_nibble, n_nibble;
    logic [1:0] cnt;
    logic       accept;
    logic [4:0] hex;
    t_bundle    bun;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;
    assign hex    = hex_decode(i_in_byte);

    always_comb begin
        bun      = '0;
        bun.has0 = 1'b1;
        cnt      = 2'd0;
        n_mode   = r_mode;
        n_nibble = r_nibble;
        if (i_end_item) begin
            bun.done = 1'b1;
            n_mode   = MODE_NORMAL;
            n_nibble = 4'd0;
            cnt      = 2'd1;
            priority case (r_mode)
                MODE_ESC: begin
                    bun.b0 = CH_BACKSLASH;
                end
                MODE_HEX0: begin
                    bun.b0 = CH_BACKSLASH;
                    bun.b1 = CH_X;
                    cnt    = 2'd2;
                end
                MODE_HEX1: begin
                    bun.b0 = {4'd0, r_nibble};
                end
                default: begin
                    bun.has0 = 1'b0;
                end
            endcase
        end else begin
            priority case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_NORMAL;
                    cnt    = 2'd1;
                    priority case (i_in_byte)
                        CH_A:         bun.b0 = CTL_BEL;
                        CH_B:         bun.b0 = CTL_BS;
                        CH_N:         bun.b0 = CTL_LF;
                        CH_R:         bun.b0 = CTL_CR;
                        CH_T:         bun.b0 = CTL_HT;
                        CH_V:         bun.b0 = CTL_VT;
                        CH_F:         bun.b0 = CTL_FF;
                        CH_BACKSLASH: bun.b0 = CH_BACKSLASH;
                        CH_C: begin
                            n_mode = MODE_QUIET;
                            cnt    = 2'd0;
                        end
                        CH_X: begin
                            n_mode = MODE_HEX0;
                            cnt    = 2'd0;
                        end
                        default: begin
                            // unknown escape: literal backslash, then the byte as plain text
                            bun.b0 = CH_BACKSLASH;
                            bun.b1 = i_in_byte;
                            cnt    = 2'd2;
                        end
                    endcase
                end
                MODE_HEX0: begin
                    if (hex[4]) begin
                        n_nibble = hex[3:0];
                        n_mode   = MODE_HEX1;
                    end else begin
                        bun.b0 = CH_BACKSLASH;
                        bun.b1 = CH_X;
                        bun.b2 = i_in_byte;
                        if (i_in_byte == CH_BACKSLASH) begin
                            n_mode = MODE_ESC;
                            cnt    = 2'd2;
                        end else begin
                            n_mode = MODE_NORMAL;
                            cnt    = 2'd3;
                        end
                    end
                end
                MODE_HEX1: begin
                    n_nibble = 4'd0;
                    if (hex[4]) begin
                        bun.b0 = {r_nibble, hex[3:0]};
                        cnt    = 2'd1;
                        n_mode = MODE_NORMAL;
                    end else begin
                        bun.b0 = {4'd0, r_nibble};
                        bun.b1 = i_in_byte;
                        if (i_in_byte == CH_BACKSLASH) begin
                            n_mode = MODE_ESC;
                            cnt    = 2'd1;
                        end else begin
                            n_mode = MODE_NORMAL;
                            cnt    = 2'd2;
                        end
                    end
                end
                MODE_QUIET: begin
                    cnt = 2'd0;
                end
                default: begin
                    bun.b0 = i_in_byte;
                    if (i_in_byte == CH_BACKSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_mode = MODE_NORMAL;
                        cnt    = 2'd1;
                    end
                end
            endcase
        end
        bun.last = cnt - 2'd1;
    end

    assign o_q_push = accept && (cnt != 2'd0);
    assign o_q_data = bun;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_nibble <= 4'd0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_nibble <= n_nibble;
        end
    end

endmodule

// ----- src/esd_queue.sv -----
// short queue of result bundles between front and back
module esd_queue
    import esd_pkg::*;
#(
    parameter int DEPTH = ESD_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    output logic    o_full,
    input  logic    i_pop,
    output t_bundle o_data,
    output logic    o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- src/esd_back.sv -----
// back end: unpacks one bundle into results, one per cycle while the consumer pops, held in an output register
module esd_back
    import esd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_bundle    i_q_data,
    input  logic       i_q_empty,
    output logic       o_q_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_string_done,
    output logic       o_last_of_run
);

    t_bundle    r_bun;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       pop_fire, at_last, take;

    assign pop_fire = i_pop && r_valid;
    assign at_last  = (r_idx == r_bun.last);
    assign take     = !r_valid || (pop_fire && at_last);
    assign o_q_pop  = take && !i_q_empty;

    assign o_empty       = !r_valid;
    assign o_has_byte    = (r_idx == 2'd0) ? r_bun.has0 : 1'b1;
    assign o_string_done = r_bun.done && at_last;
    assign o_last_of_run = at_last;

    always_comb begin
        unique case (r_idx)
            2'd0:    o_out_byte = r_bun.b0;
            2'd1:    o_out_byte = r_bun.b1;
            default: o_out_byte = r_bun.b2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_q_empty) begin
            r_bun <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (take) begin
            r_valid <= !i_q_empty;
            r_idx   <= 2'd0;
        end else if (pop_fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_bun.last))
        else $error("result index beyond end of bundle");

    a_marker_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_has_byte) |-> (o_string_done && o_last_of_run && r_idx == 2'd0))
        else $error("empty marker not a lone closing result");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_fire && !at_last) |=> (r_valid && r_idx == $past(r_idx) + 2'd1))
        else $error("result index did not advance after pop");
`endif

endmodule
